// File: rtl/core/pfx_pkg.sv
// Shared types, codes and helpers for the PFCP frame element extractor.
package pfx_pkg;

    localparam int MaxRes  = 4;
    localparam int CapDepth = 13;

    typedef enum logic [2:0] {
        PH_ETH,
        PH_IP,
        PH_UDP,
        PH_HDR,
        PH_IEHDR,
        PH_IEVAL,
        PH_DRAIN
    } t_phase;

    typedef enum logic [4:0] {
        K_REJECT     = 5'd0,
        K_HEADER     = 5'd1,
        K_SEID       = 5'd2,
        K_SEQUENCE   = 5'd3,
        K_ELEM_SEEN  = 5'd4,
        K_FTEID      = 5'd5,
        K_FTEID_NONE = 5'd6,
        K_IPV4       = 5'd7,
        K_IPV6       = 5'd8,
        K_FSEID      = 5'd9,
        K_QFI        = 5'd10,
        K_PRECEDENCE = 5'd11,
        K_PDR        = 5'd12,
        K_FAR        = 5'd13,
        K_SHORT_HDR  = 5'd14,
        K_INCOMPLETE = 5'd15,
        K_DONE       = 5'd16
    } t_kind;

    localparam logic [1:0] CFG_CLIENT = 2'd0;
    localparam logic [1:0] CFG_SERVER = 2'd1;
    localparam logic [1:0] CFG_PORT   = 2'd2;

    localparam logic [15:0] IE_FTEID      = 16'h0039;
    localparam logic [15:0] IE_UE_IP      = 16'h0056;
    localparam logic [15:0] IE_FSEID      = 16'h001C;
    localparam logic [15:0] IE_QFI        = 16'h005D;
    localparam logic [15:0] IE_PRECEDENCE = 16'h002C;
    localparam logic [15:0] IE_PDR_ID     = 16'h0016;
    localparam logic [15:0] IE_FAR_ID     = 16'h0014;

    typedef struct packed {
        logic [31:0] client;
        logic [31:0] server;
        logic [15:0] port;
    } t_cfg;

    typedef struct packed {
        t_kind       kind;
        logic [63:0] value;
        logic [15:0] etype;
        logic [15:0] elen;
        logic [7:0]  side;
        logic        last;
    } t_res;

    typedef struct packed {
        t_res [MaxRes-1:0] res;
        logic [2:0]        cnt;
    } t_step;

    function automatic t_res mk_res(t_kind k, logic [63:0] v, logic [15:0] t,
                                    logic [15:0] l, logic [7:0] s);
        t_res r;
        r.kind  = k;
        r.value = v;
        r.etype = t;
        r.elen  = l;
        r.side  = s;
        r.last  = (k == K_REJECT) || (k == K_DONE);
        return r;
    endfunction

endpackage

// File: rtl/core/pfx_parser.sv
// Byte-wide frame parser: state registers and the per-byte step logic.
module pfx_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [7:0]         i_byte,
    input  logic               i_end,
    input  pfx_pkg::t_cfg      i_cfg,
    output pfx_pkg::t_step     o_step
);

    logic [15:0]     r_off, n_off;
    pfx_pkg::t_phase r_ph, n_ph;
    logic [5:0]      r_ihl, n_ihl;
    logic [31:0]     r_src, n_src, r_dst, n_dst;
    logic [7:0]      r_flags, n_flags;
    logic [15:0]     r_rem, n_rem, r_ctype, n_ctype, r_clen, n_clen, r_vc, n_vc;
    logic [7:0]      r_cap [pfx_pkg::CapDepth];
    logic [7:0]      n_cap [pfx_pkg::CapDepth];

    always_comb begin
        pfx_pkg::t_step st;
        logic           halt;
        logic [4:0]     hs;
        logic [4:0]     seq_end;
        logic [15:0]    ulen;
        logic [63:0]    v;
        n_off = r_off; n_ph = r_ph; n_ihl = r_ihl; n_src = r_src; n_dst = r_dst;
        n_flags = r_flags; n_rem = r_rem; n_ctype = r_ctype; n_clen = r_clen;
        n_vc = r_vc;
        n_cap = r_cap;
        st = '0;
        halt = 1'b0;
        hs = '0;
        seq_end = '0;
        ulen = '0;
        v = '0;

        case (r_ph)
            pfx_pkg::PH_ETH: begin
                if (r_off == 16'd12) n_cap[0] = i_byte;
                if (r_off == 16'd13) begin
                    if ({r_cap[0], i_byte} != 16'h0800) begin
                        st.res[st.cnt[1:0]] = pfx_pkg::mk_res(pfx_pkg::K_REJECT, '0, '0, '0, '0);
                        st.cnt = st.cnt + 3'd1;
                        n_ph = pfx_pkg::PH_DRAIN;
                    end else begin
                        n_ph = pfx_pkg::PH_IP;
                    end
                end
            end
            pfx_pkg::PH_IP: begin
                if (r_off == 16'd14) begin
                    if (i_byte[3:0] < 4'd5) halt = 1'b1;
                    else n_ihl = {i_byte[3:0], 2'b00};
                end
                if (!halt && r_off == 16'd23 && i_byte != 8'd17) halt = 1'b1;
                if (!halt) begin
                    if (r_off >= 16'd26 && r_off <= 16'd29) n_src = {r_src[23:0], i_byte};
                    if (r_off >= 16'd30 && r_off <= 16'd33) n_dst = {r_dst[23:0], i_byte};
                    if (r_off == 16'd33 &&
                        !(n_src == i_cfg.client && n_dst == i_cfg.server) &&
                        !(n_src == i_cfg.server && n_dst == i_cfg.client))
                        halt = 1'b1;
                end
                if (halt) begin
                    st.res[st.cnt[1:0]] = pfx_pkg::mk_res(pfx_pkg::K_REJECT, '0, '0, '0, '0);
                    st.cnt = st.cnt + 3'd1;
                    n_ph = pfx_pkg::PH_DRAIN;
                end else if (r_off >= 16'd33 && r_off == 16'd13 + {10'd0, r_ihl}) begin
                    n_ph = pfx_pkg::PH_UDP;
                    n_vc = '0;
                end
            end
            pfx_pkg::PH_UDP: begin
                if (r_vc < 16'd6) n_cap[r_vc[3:0]] = i_byte;
                if (r_vc == 16'd3 && {n_cap[0], n_cap[1]} != i_cfg.port &&
                    {n_cap[2], n_cap[3]} != i_cfg.port)
                    halt = 1'b1;
                if (!halt && r_vc == 16'd5) begin
                    ulen = {n_cap[4], n_cap[5]};
                    if (ulen < 16'd12) halt = 1'b1;
                    else n_rem = ulen - 16'd8;
                end
                if (halt) begin
                    st.res[st.cnt[1:0]] = pfx_pkg::mk_res(pfx_pkg::K_REJECT, '0, '0, '0, '0);
                    st.cnt = st.cnt + 3'd1;
                    n_ph = pfx_pkg::PH_DRAIN;
                end else if (r_vc >= 16'd7) begin
                    n_ph = pfx_pkg::PH_HDR;
                    n_vc = '0;
                end else begin
                    n_vc = r_vc + 16'd1;
                end
            end
            pfx_pkg::PH_HDR: begin
                if (r_rem != '0) n_rem = r_rem - 16'd1;
                if (r_vc == 16'd0) n_flags = i_byte;
                else if (r_vc <= 16'd3) n_cap[r_vc[3:0] - 4'd1] = i_byte;
                else if (r_vc <= 16'd16) n_cap[r_vc[3:0] - 4'd4] = i_byte;
                hs = (n_flags[0] ? 5'd16 : 5'd8) + {4'd0, n_flags[1]};
                seq_end = n_flags[0] ? 5'd14 : 5'd6;
                n_vc = r_vc + 16'd1;
                if (r_vc == 16'd3) begin
                    v = {35'd0, n_flags[0], n_flags[1], n_flags[7:5],
                         n_cap[0], n_cap[1], n_cap[2]};
                    st.res[st.cnt[1:0]] = pfx_pkg::mk_res(pfx_pkg::K_HEADER, v, '0, '0, '0);
                    st.cnt = st.cnt + 3'd1;
                    if (n_rem <= {11'd0, hs - 5'd4}) begin
                        st.res[st.cnt[1:0]] = pfx_pkg::mk_res(pfx_pkg::K_DONE, '0, '0, '0, '0);
                        st.cnt = st.cnt + 3'd1;
                        n_ph = pfx_pkg::PH_DRAIN;
                        n_vc = r_vc;
                    end
                end else if (r_vc == {11'd0, seq_end}) begin
                    if (n_flags[0]) begin
                        v = {n_cap[0], n_cap[1], n_cap[2], n_cap[3],
                             n_cap[4], n_cap[5], n_cap[6], n_cap[7]};
                        st.res[st.cnt[1:0]] = pfx_pkg::mk_res(pfx_pkg::K_SEID, v, '0, '0, '0);
                        st.cnt = st.cnt + 3'd1;
                        v = {40'd0, n_cap[8], n_cap[9], n_cap[10]};
                    end else begin
                        v = {40'd0, n_cap[0], n_cap[1], n_cap[2]};
                    end
                    st.res[st.cnt[1:0]] = pfx_pkg::mk_res(pfx_pkg::K_SEQUENCE, v, '0, '0, '0);
                    st.cnt = st.cnt + 3'd1;
                end else if (r_vc == {11'd0, hs - 5'd1}) begin
                    n_ph = pfx_pkg::PH_IEHDR;
                    n_vc = '0;
                end
            end
            pfx_pkg::PH_IEHDR: begin
                if (r_rem != '0) n_rem = r_rem - 16'd1;
                case (r_vc)
                    16'd0: begin
                        n_ctype = {i_byte, 8'd0};
                        n_clen  = '0;
                    end
                    16'd1: n_ctype = {r_ctype[15:8], i_byte};
                    16'd2: n_clen  = {i_byte, 8'd0};
                    default: n_clen = {r_clen[15:8], i_byte};
                endcase
                n_vc = r_vc + 16'd1;
                if (n_vc >= 16'd4) begin
                    st.res[st.cnt[1:0]] =
                        pfx_pkg::mk_res(pfx_pkg::K_ELEM_SEEN, '0, n_ctype, n_clen, '0);
                    st.cnt = st.cnt + 3'd1;
                    n_vc = '0;
                    if (n_clen > n_rem) begin
                        st.res[st.cnt[1:0]] =
                            pfx_pkg::mk_res(pfx_pkg::K_INCOMPLETE, '0, n_ctype, n_clen, '0);
                        st.cnt = st.cnt + 3'd1;
                        st.res[st.cnt[1:0]] = pfx_pkg::mk_res(pfx_pkg::K_DONE, '0, '0, '0, '0);
                        st.cnt = st.cnt + 3'd1;
                        n_ph = pfx_pkg::PH_DRAIN;
                    end else if (n_clen == '0) begin
                        if (n_rem == '0) begin
                            st.res[st.cnt[1:0]] =
                                pfx_pkg::mk_res(pfx_pkg::K_DONE, '0, '0, '0, '0);
                            st.cnt = st.cnt + 3'd1;
                            n_ph = pfx_pkg::PH_DRAIN;
                        end
                    end else begin
                        n_ph = pfx_pkg::PH_IEVAL;
                    end
                end else if (n_rem == '0) begin
                    st.res[st.cnt[1:0]] =
                        pfx_pkg::mk_res(pfx_pkg::K_SHORT_HDR, '0, n_ctype, n_clen, '0);
                    st.cnt = st.cnt + 3'd1;
                    st.res[st.cnt[1:0]] = pfx_pkg::mk_res(pfx_pkg::K_DONE, '0, '0, '0, '0);
                    st.cnt = st.cnt + 3'd1;
                    n_ph = pfx_pkg::PH_DRAIN;
                end
            end
            pfx_pkg::PH_IEVAL: begin
                if (r_rem != '0) n_rem = r_rem - 16'd1;
                if (r_vc < 16'd13) n_cap[r_vc[3:0]] = i_byte;
                n_vc = r_vc + 16'd1;
                if (n_vc >= r_clen) begin
                    // The element is complete: decode the known types.
                    case (r_ctype)
                        pfx_pkg::IE_FTEID: begin
                            if (r_clen >= 16'd5) begin
                                if (n_cap[1][0] && r_clen >= 16'd9) begin
                                    v = {32'd0, n_cap[2], n_cap[3], n_cap[4], n_cap[5]};
                                    st.res[st.cnt[1:0]] = pfx_pkg::mk_res(pfx_pkg::K_FTEID,
                                        v, r_ctype, r_clen, n_cap[0]);
                                end else begin
                                    st.res[st.cnt[1:0]] = pfx_pkg::mk_res(
                                        pfx_pkg::K_FTEID_NONE, '0, r_ctype, r_clen, n_cap[0]);
                                end
                                st.cnt = st.cnt + 3'd1;
                            end
                        end
                        pfx_pkg::IE_UE_IP: begin
                            if (n_cap[0][7] && r_clen >= 16'd5) begin
                                v = {32'd0, n_cap[1], n_cap[2], n_cap[3], n_cap[4]};
                                st.res[st.cnt[1:0]] =
                                    pfx_pkg::mk_res(pfx_pkg::K_IPV4, v, r_ctype, r_clen, '0);
                                st.cnt = st.cnt + 3'd1;
                            end
                            if (n_cap[0][6] && r_clen >= 16'd21) begin
                                st.res[st.cnt[1:0]] =
                                    pfx_pkg::mk_res(pfx_pkg::K_IPV6, '0, r_ctype, r_clen, '0);
                                st.cnt = st.cnt + 3'd1;
                            end
                        end
                        pfx_pkg::IE_FSEID: begin
                            if (r_clen >= 16'd9) begin
                                v = {n_cap[1], n_cap[2], n_cap[3], n_cap[4],
                                     n_cap[5], n_cap[6], n_cap[7], n_cap[8]};
                                st.res[st.cnt[1:0]] =
                                    pfx_pkg::mk_res(pfx_pkg::K_FSEID, v, r_ctype, r_clen, '0);
                                st.cnt = st.cnt + 3'd1;
                            end
                        end
                        pfx_pkg::IE_QFI: begin
                            v = {58'd0, n_cap[0][5:0]};
                            st.res[st.cnt[1:0]] =
                                pfx_pkg::mk_res(pfx_pkg::K_QFI, v, r_ctype, r_clen, '0);
                            st.cnt = st.cnt + 3'd1;
                        end
                        pfx_pkg::IE_PRECEDENCE: begin
                            if (r_clen >= 16'd3) begin
                                v = {40'd0, n_cap[0], n_cap[1], n_cap[2]};
                                st.res[st.cnt[1:0]] = pfx_pkg::mk_res(pfx_pkg::K_PRECEDENCE,
                                    v, r_ctype, r_clen, '0);
                                st.cnt = st.cnt + 3'd1;
                            end
                        end
                        pfx_pkg::IE_PDR_ID: begin
                            if (r_clen >= 16'd2) begin
                                v = {48'd0, n_cap[0], n_cap[1]};
                                st.res[st.cnt[1:0]] =
                                    pfx_pkg::mk_res(pfx_pkg::K_PDR, v, r_ctype, r_clen, '0);
                                st.cnt = st.cnt + 3'd1;
                            end
                        end
                        pfx_pkg::IE_FAR_ID: begin
                            if (r_clen >= 16'd2) begin
                                v = {48'd0, n_cap[0], n_cap[1]};
                                st.res[st.cnt[1:0]] =
                                    pfx_pkg::mk_res(pfx_pkg::K_FAR, v, r_ctype, r_clen, '0);
                                st.cnt = st.cnt + 3'd1;
                            end
                        end
                        default: ;
                    endcase
                    n_ph = pfx_pkg::PH_IEHDR;
                    n_vc = '0;
                    if (n_rem == '0) begin
                        st.res[st.cnt[1:0]] = pfx_pkg::mk_res(pfx_pkg::K_DONE, '0, '0, '0, '0);
                        st.cnt = st.cnt + 3'd1;
                        n_ph = pfx_pkg::PH_DRAIN;
                    end
                end
            end
            default: ;
        endcase

        if (r_off != 16'hFFFF) n_off = r_off + 16'd1;

        if (i_end) begin
            case (n_ph)
                pfx_pkg::PH_ETH, pfx_pkg::PH_IP, pfx_pkg::PH_UDP: begin
                    st.res[st.cnt[1:0]] = pfx_pkg::mk_res(pfx_pkg::K_REJECT, '0, '0, '0, '0);
                    st.cnt = st.cnt + 3'd1;
                end
                pfx_pkg::PH_HDR: begin
                    st.res[st.cnt[1:0]] = pfx_pkg::mk_res(
                        (n_vc >= 16'd4) ? pfx_pkg::K_DONE : pfx_pkg::K_REJECT,
                        '0, '0, '0, '0);
                    st.cnt = st.cnt + 3'd1;
                end
                pfx_pkg::PH_IEHDR: begin
                    if (n_vc != '0) begin
                        st.res[st.cnt[1:0]] =
                            pfx_pkg::mk_res(pfx_pkg::K_SHORT_HDR, '0, n_ctype, n_clen, '0);
                        st.cnt = st.cnt + 3'd1;
                    end
                    st.res[st.cnt[1:0]] = pfx_pkg::mk_res(pfx_pkg::K_DONE, '0, '0, '0, '0);
                    st.cnt = st.cnt + 3'd1;
                end
                pfx_pkg::PH_IEVAL: begin
                    st.res[st.cnt[1:0]] =
                        pfx_pkg::mk_res(pfx_pkg::K_INCOMPLETE, '0, n_ctype, n_clen, '0);
                    st.cnt = st.cnt + 3'd1;
                    st.res[st.cnt[1:0]] = pfx_pkg::mk_res(pfx_pkg::K_DONE, '0, '0, '0, '0);
                    st.cnt = st.cnt + 3'd1;
                end
                default: ;
            endcase
            n_ph  = pfx_pkg::PH_ETH;
            n_off = '0;
            n_vc  = '0;
        end
        o_step = st;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off   <= '0;
            r_ph    <= pfx_pkg::PH_ETH;
            r_ihl   <= '0;
            r_src   <= '0;
            r_dst   <= '0;
            r_flags <= '0;
            r_rem   <= '0;
            r_ctype <= '0;
            r_clen  <= '0;
            r_vc    <= '0;
        end else if (i_accept) begin
            r_off   <= n_off;
            r_ph    <= n_ph;
            r_ihl   <= n_ihl;
            r_src   <= n_src;
            r_dst   <= n_dst;
            r_flags <= n_flags;
            r_rem   <= n_rem;
            r_ctype <= n_ctype;
            r_clen  <= n_clen;
            r_vc    <= n_vc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) r_cap <= n_cap;
    end

endmodule

// File: rtl/core/pfx_result_queue.sv
// Holds the results of one item and presents them one at a time on the output register.
module pfx_result_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  pfx_pkg::t_step  i_step,
    output logic            o_valid,
    input  logic            i_stall,
    output pfx_pkg::t_res   o_res
);

    pfx_pkg::t_res [pfx_pkg::MaxRes-1:0] r_q;
    logic [1:0]    r_head;
    logic [2:0]    r_cnt;
    logic          r_ov;
    pfx_pkg::t_res r_o;
    logic          pop;
    logic          accept;

    assign pop     = (r_cnt != 3'd0) && (!r_ov || !i_stall);
    // A new item is taken once its results can replace what is left.
    assign o_stall = !((r_cnt == 3'd0) || (r_cnt == 3'd1 && pop));
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_cnt  <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (accept) begin
                r_head <= '0;
                r_cnt  <= i_step.cnt;
            end else if (pop) begin
                r_head <= r_head + 2'd1;
                r_cnt  <= r_cnt - 3'd1;
            end
            if (pop) r_ov <= 1'b1;
            else if (!i_stall) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_q <= i_step.res;
        if (pop) r_o <= r_q[r_head];
    end

    assign o_valid = r_ov;
    assign o_res   = r_o;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'(pfx_pkg::MaxRes)) else $error("result count overflow");
    a_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_head} + r_cnt) <= 4'(pfx_pkg::MaxRes)) else $error("queue span overflow");
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_cnt == $past(i_step.cnt)) else $error("results not loaded");
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> (r_cnt == 3'd0 || pop)) else $error("results overwritten");

endmodule

// File: rtl/core/pfcp_frame_ie_extractor.sv
// Top level of the PFCP frame element extractor.
// Usage: an Ethernet frame enters one byte per item on the input channel
// (i_frame_byte, with i_frame_end high on its final byte). Each byte may give
// up to three results on the output channel: PFCP header, SEID, sequence and
// one or more results per information element, with o_last_of_frame high on
// the single reject or done result that closes every frame.
// The three registers (client address, server address, session port) are
// written through the configuration channel, which is always ready.
// The first result of a byte passes through the result queue and then the
// output register; further results of the same byte follow one per cycle
// while the receiver does not stall.
// Throughput: one byte per cycle while each byte gives at most one result
// and the receiver does not stall; a byte giving more results holds the
// input until the single output register pulls the last one from the queue.
// Reset is synchronous and active low: the parser waits for a new frame, the
// result queue empties and the session port returns to 8805.
// When the receiver stalls the output item holds; the input stalls once the
// queued results of the previous byte cannot be moved on.
module pfcp_frame_ie_extractor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_frame_byte,
    input  logic        i_frame_end,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [4:0]  o_kind,
    output logic [63:0] o_field_value,
    output logic [15:0] o_element_type,
    output logic [15:0] o_element_length,
    output logic [7:0]  o_side_byte,
    output logic        o_last_of_frame,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    pfx_pkg::t_cfg  r_cfg;
    pfx_pkg::t_step step;
    pfx_pkg::t_res  res;
    logic           accept;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.client <= '0;
            r_cfg.server <= '0;
            r_cfg.port   <= 16'd8805;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pfx_pkg::CFG_CLIENT: r_cfg.client <= i_cfg_data;
                pfx_pkg::CFG_SERVER: r_cfg.server <= i_cfg_data;
                pfx_pkg::CFG_PORT:   r_cfg.port   <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign accept = i_in_valid && !o_in_stall;

    pfx_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_frame_byte),
        .i_end    (i_frame_end),
        .i_cfg    (r_cfg),
        .o_step   (step)
    );

    pfx_result_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_step  (step),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_res   (res)
    );

    assign o_kind           = res.kind;
    assign o_field_value    = res.value;
    assign o_element_type   = res.etype;
    assign o_element_length = res.elen;
    assign o_side_byte      = res.side;
    assign o_last_of_frame  = res.last;

endmodule
